// File: rtl/core/gwv_pkg.sv
package gwv_pkg;

	localparam int MAX_GROUPS_DEF = 256;

	localparam logic [47:0] ONE_Q16 = 48'h0000_0001_0000;
	localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] CAP64 = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [1:0] REQ_ACC = 2'd0;
	localparam logic [1:0] REQ_QRY = 2'd1;
	localparam logic [1:0] REQ_CLR = 2'd2;

	localparam logic [2:0] REG_GROUPS = 3'd0;
	localparam logic [2:0] REG_RUNNING = 3'd1;
	localparam logic [2:0] REG_STD_DEV = 3'd2;
	localparam logic [2:0] REG_SKIP = 3'd3;
	localparam logic [2:0] REG_WEIGHTS = 3'd4;

	// One group's accumulator as it sits in the table.
	typedef struct packed {
		logic        poisoned;
		logic [47:0] wsum;
		logic [63:0] m2;
		logic [63:0] m1;
	} entry_t;

endpackage

// File: rtl/core/grouped_weighted_variance.sv
// Grouped weighted variance engine. One request is taken when start is high and busy is low;
// the block then works on it alone. In running-mean mode an accumulate request uses the
// shared multiplier and the divider, and in sum mode the multiplier only. A variance query
// uses the divider, and in sum mode the multiplier as well; a standard deviation adds a
// square root. A clear writes an empty entry for its group. The work is done by one shared
// 64x64 multiplier that forms four 32x32 partial products, a radix-2 divider that forms each
// 128-bit quotient, and a square root that yields one bit a cycle. Requests for inactive
// groups or of unknown type cost nothing and never set busy. A query presents its result for
// exactly one cycle with result_strobe high; the receiver must take it then. After reset the
// table is cleared one group a cycle, so busy stays high until every group is cleared;
// configuration writes are taken at any time.
module grouped_weighted_variance
	import gwv_pkg::*;
#(
	parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  group_index,
	input  logic [31:0] sample,
	input  logic        sample_missing,
	input  logic [31:0] weight,
	input  logic        weight_missing,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        result_strobe,
	output logic [7:0]  result_group,
	output logic [47:0] spread,
	output logic        result_na,
	output logic [47:0] total_weight
);

	localparam int AW = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
	localparam int EW = $bits(entry_t);

	typedef enum logic [18:0] {
		ST_CLEAR  = 19'h00001,
		ST_IDLE   = 19'h00002,
		ST_DECIDE = 19'h00004,
		ST_MUL    = 19'h00008,
		ST_DIV    = 19'h00010,
		ST_SQRT   = 19'h00020,
		ST_R_DIV  = 19'h00040,
		ST_R_MEAN = 19'h00080,
		ST_R_E    = 19'h00100,
		ST_R_T    = 19'h00200,
		ST_R_INC  = 19'h00400,
		ST_S_WX   = 19'h00800,
		ST_S_SQ   = 19'h01000,
		ST_S_ACC  = 19'h02000,
		ST_Q_DIV  = 19'h04000,
		ST_Q_NUM  = 19'h08000,
		ST_Q_SPR  = 19'h10000,
		ST_Q_FIN  = 19'h20000,
		ST_Q_ROOT = 19'h40000
	} state_t;

	state_t state_q, nxt, ret_q, ret_nxt;

	logic [8:0]  groups_q;
	logic        running_q, std_q, skip_q, wts_q;

	logic [1:0]  req_q;
	logic [7:0]  grp_q;
	logic [31:0] x_q;
	logic [31:0] w_q;
	logic        miss_q;
	logic [AW-1:0] clr_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	entry_t        ent, wr_ent;

	// shared multiplier
	logic [63:0]  ma_q, mb_q, mul_a, mul_b;
	logic [127:0] acc_q, pp_sh;
	logic [1:0]   mcnt_q;
	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic         mul_go;

	// shared divider
	logic [127:0] dvd_q, div_n;
	logic [47:0]  drem_q, dsor_q, div_d;
	logic [48:0]  dtry;
	logic         dbit;
	logic [6:0]   dcnt_q;
	logic         div_go;

	// square root
	logic [127:0] rad_q;
	logic [66:0]  srem_q, s_r2, s_trial;
	logic [63:0]  root_q;
	logic [5:0]   scnt_q;
	logic         sqrt_go;

	// item working values
	logic [63:0] xs, d, dm, e, em, xm;
	logic [48:0] wsum49;
	logic [47:0] wnew, wnew_q;
	logic [63:0] dm_q, m1_q, num_q;
	logic        dneg_q;
	logic        m1_ld, num_ld, dm_ld;
	logic [63:0] m1_nxt, num_nxt;
	logic [47:0] wx_mag;
	logic [63:0] wx;
	logic [64:0] s1sum, m2sum;
	logic [63:0] m2_inc, m2_new, s1_abs;
	logic        item_ok;
	logic        out_ld, out_na;
	logic [47:0] out_spread;

	assign busy = (state_q != ST_IDLE);
	assign ent = entry_t'(ram_rdata);

	assign item_ok = ({1'b0, group_index} < groups_q) && (32'(group_index) < MAX_GROUPS)
		&& (req_type == REQ_ACC || req_type == REQ_QRY || req_type == REQ_CLR);
	assign ram_re = (state_q == ST_IDLE) && start;

	gwv_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_GROUPS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(AW'(group_index)),
		.rdata(ram_rdata)
	);

	assign ram_wdata = EW'(wr_ent);

	// Datapath helpers.
	assign xs = {{16{x_q[31]}}, x_q, 16'h0000};
	assign xm = {32'h0, (x_q[31] ? 32'(-x_q) : x_q)};
	assign wsum49 = {1'b0, ent.wsum} + {17'h0, w_q};
	assign wnew = wsum49[48] ? CAP48 : wsum49[47:0];
	assign d = xs - ent.m1;
	assign dm = d[63] ? 64'(-d) : d;
	assign e = xs - m1_q;
	assign em = e[63] ? 64'(-e) : e;
	assign s1_abs = ent.m1[63] ? 64'(-ent.m1) : ent.m1;

	// Sum mode: w*x truncated toward zero, then a saturating signed add.
	assign wx_mag = acc_q[63:16];
	assign wx = x_q[31] ? 64'(-{16'h0, wx_mag}) : {16'h0, wx_mag};
	assign s1sum = {ent.m1[63], ent.m1} + {wx[63], wx};

	always_comb begin
		m2_inc = acc_q[95:32];
		if (state_q == ST_R_INC) begin
			m2_inc = (acc_q[127:80] != '0) ? CAP64 : acc_q[79:16];
		end
	end
	assign m2sum = {1'b0, ent.m2} + {1'b0, m2_inc};
	assign m2_new = m2sum[64] ? CAP64 : m2sum[63:0];

	// Multiplier partial product for the current quarter.
	assign ah = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign bh = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp = ah * bh;
	always_comb begin
		unique case (mcnt_q)
			2'd0: pp_sh = {64'h0, pp};
			2'd3: pp_sh = {pp, 64'h0};
			default: pp_sh = {32'h0, pp, 32'h0};
		endcase
	end

	assign dtry = {drem_q, dvd_q[127]};
	assign dbit = (dtry >= {1'b0, dsor_q});

	assign s_r2 = {srem_q[64:0], rad_q[127:126]};
	assign s_trial = {1'b0, root_q, 2'b01};

	always_comb begin
		nxt = state_q;
		ret_nxt = ret_q;
		mul_go = 1'b0;
		mul_a = 64'h0;
		mul_b = 64'h0;
		div_go = 1'b0;
		div_n = 128'h0;
		div_d = 48'h0;
		sqrt_go = 1'b0;
		ram_we = 1'b0;
		ram_waddr = AW'(grp_q);
		wr_ent = ent;
		m1_ld = 1'b0;
		m1_nxt = 64'h0;
		num_ld = 1'b0;
		num_nxt = 64'h0;
		dm_ld = 1'b0;
		out_ld = 1'b0;
		out_na = 1'b0;
		out_spread = 48'h0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				wr_ent = '0;
				if (clr_q == AW'(MAX_GROUPS - 1)) begin
					nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && item_ok) begin
					nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				nxt = ST_IDLE;
				priority case (req_q)
					REQ_ACC: begin
						if (ent.poisoned) begin
							nxt = ST_IDLE;
						end else if (miss_q) begin
							if (!skip_q) begin
								ram_we = 1'b1;
								wr_ent.poisoned = 1'b1;
							end
						end else if (running_q) begin
							if (wnew != '0) begin
								dm_ld = 1'b1;
								mul_go = 1'b1;
								mul_a = dm;
								mul_b = {32'h0, w_q};
								nxt = ST_MUL;
								ret_nxt = ST_R_DIV;
							end
						end else begin
							mul_go = 1'b1;
							mul_a = xm;
							mul_b = {32'h0, w_q};
							nxt = ST_MUL;
							ret_nxt = ST_S_WX;
						end
					end
					REQ_CLR: begin
						ram_we = 1'b1;
						wr_ent = '0;
					end
					default: begin
						if (ent.poisoned || ent.wsum <= ONE_Q16) begin
							out_ld = 1'b1;
							out_na = 1'b1;
						end else if (running_q) begin
							num_ld = 1'b1;
							num_nxt = ent.m2;
							nxt = ST_Q_SPR;
						end else begin
							mul_go = 1'b1;
							mul_a = s1_abs;
							mul_b = s1_abs;
							nxt = ST_MUL;
							ret_nxt = ST_Q_DIV;
						end
					end
				endcase
			end
			ST_MUL: begin
				if (mcnt_q == 2'd3) begin
					nxt = ret_q;
				end
			end
			ST_DIV: begin
				if (dcnt_q == 7'd127) begin
					nxt = ret_q;
				end
			end
			ST_SQRT: begin
				if (scnt_q == 6'd63) begin
					nxt = ret_q;
				end
			end
			ST_R_DIV: begin
				div_go = 1'b1;
				div_n = acc_q;
				div_d = wnew_q;
				nxt = ST_DIV;
				ret_nxt = ST_R_MEAN;
			end
			ST_R_MEAN: begin
				m1_ld = 1'b1;
				m1_nxt = dneg_q ? ent.m1 - dvd_q[63:0] : ent.m1 + dvd_q[63:0];
				nxt = ST_R_E;
			end
			ST_R_E: begin
				mul_go = 1'b1;
				mul_a = dm_q;
				mul_b = em;
				nxt = ST_MUL;
				ret_nxt = ST_R_T;
			end
			ST_R_T: begin
				mul_go = 1'b1;
				mul_a = acc_q[111:48];
				mul_b = {32'h0, w_q};
				nxt = ST_MUL;
				ret_nxt = ST_R_INC;
			end
			ST_R_INC, ST_S_ACC: begin
				ram_we = 1'b1;
				wr_ent.poisoned = 1'b0;
				wr_ent.wsum = wnew_q;
				wr_ent.m2 = m2_new;
				wr_ent.m1 = m1_q;
				nxt = ST_IDLE;
			end
			ST_S_WX: begin
				m1_ld = 1'b1;
				if (s1sum[64] != s1sum[63]) begin
					m1_nxt = s1sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
				end else begin
					m1_nxt = s1sum[63:0];
				end
				mul_go = 1'b1;
				mul_a = xm;
				mul_b = xm;
				nxt = ST_MUL;
				ret_nxt = ST_S_SQ;
			end
			ST_S_SQ: begin
				mul_go = 1'b1;
				mul_a = acc_q[63:0];
				mul_b = {32'h0, w_q};
				nxt = ST_MUL;
				ret_nxt = ST_S_ACC;
			end
			ST_Q_DIV: begin
				div_go = 1'b1;
				div_n = acc_q;
				div_d = ent.wsum;
				nxt = ST_DIV;
				ret_nxt = ST_Q_NUM;
			end
			ST_Q_NUM: begin
				num_ld = 1'b1;
				// A negative numerator from truncation is taken as zero.
				if (dvd_q[127:64] != '0 || dvd_q[63:0] > ent.m2) begin
					num_nxt = 64'h0;
				end else begin
					num_nxt = ent.m2 - dvd_q[63:0];
				end
				nxt = ST_Q_SPR;
			end
			ST_Q_SPR: begin
				div_go = 1'b1;
				div_n = std_q ? {32'h0, num_q, 32'h0} : {48'h0, num_q, 16'h0};
				div_d = ent.wsum - ONE_Q16;
				nxt = ST_DIV;
				ret_nxt = ST_Q_FIN;
			end
			ST_Q_FIN: begin
				if (std_q) begin
					sqrt_go = 1'b1;
					nxt = ST_SQRT;
					ret_nxt = ST_Q_ROOT;
				end else begin
					out_ld = 1'b1;
					out_spread = (dvd_q[127:48] != '0) ? CAP48 : dvd_q[47:0];
					nxt = ST_IDLE;
				end
			end
			ST_Q_ROOT: begin
				out_ld = 1'b1;
				out_spread = (root_q[63:48] != '0) ? CAP48 : root_q[47:0];
				nxt = ST_IDLE;
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q <= ST_IDLE;
			clr_q <= '0;
			mcnt_q <= '0;
			dcnt_q <= '0;
			scnt_q <= '0;
			result_strobe <= 1'b0;
			groups_q <= 9'd256;
			running_q <= 1'b1;
			std_q <= 1'b1;
			skip_q <= 1'b1;
			wts_q <= 1'b0;
		end else begin
			state_q <= nxt;
			ret_q <= ret_nxt;
			result_strobe <= out_ld;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (mul_go) begin
				mcnt_q <= '0;
			end else if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (div_go) begin
				dcnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (sqrt_go) begin
				scnt_q <= '0;
			end else if (state_q == ST_SQRT) begin
				scnt_q <= scnt_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GROUPS: groups_q <= cfg_data;
					REG_RUNNING: running_q <= cfg_data[0];
					REG_STD_DEV: std_q <= cfg_data[0];
					REG_SKIP: skip_q <= cfg_data[0];
					REG_WEIGHTS: wts_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			req_q <= req_type;
			grp_q <= group_index;
			x_q <= sample;
			w_q <= wts_q ? weight : ONE_Q16[31:0];
			miss_q <= sample_missing | (wts_q & weight_missing);
		end
		if (state_q == ST_DECIDE) begin
			wnew_q <= wnew;
		end
		if (dm_ld) begin
			dm_q <= dm;
			dneg_q <= d[63];
		end
		if (m1_ld) begin
			m1_q <= m1_nxt;
		end
		if (num_ld) begin
			num_q <= num_nxt;
		end

		if (mul_go) begin
			ma_q <= mul_a;
			mb_q <= mul_b;
			acc_q <= '0;
		end else if (state_q == ST_MUL) begin
			acc_q <= acc_q + pp_sh;
		end

		// Restoring division: the dividend shifts out as quotient bits shift in.
		if (div_go) begin
			dvd_q <= div_n;
			dsor_q <= div_d;
			drem_q <= '0;
		end else if (state_q == ST_DIV) begin
			drem_q <= dbit ? 48'(dtry - {1'b0, dsor_q}) : dtry[47:0];
			dvd_q <= {dvd_q[126:0], dbit};
		end

		if (sqrt_go) begin
			rad_q <= dvd_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (state_q == ST_SQRT) begin
			rad_q <= {rad_q[125:0], 2'b00};
			if (s_r2 >= s_trial) begin
				srem_q <= s_r2 - s_trial;
				root_q <= {root_q[62:0], 1'b1};
			end else begin
				srem_q <= s_r2;
				root_q <= {root_q[62:0], 1'b0};
			end
		end

		if (out_ld) begin
			result_group <= grp_q;
			spread <= out_spread;
			result_na <= out_na;
			total_weight <= ent.wsum;
		end
	end

endmodule

// File: rtl/core/gwv_ram.sv
module gwv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: verif/grouped_weighted_variance_test.sv
module grouped_weighted_variance_test;
	import gwv_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [7:0]  grp;
		logic [47:0] spr;
		logic        na;
		logic [47:0] tw;
	} spread_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [7:0]  group_index;
	logic [31:0] sample;
	logic        sample_missing;
	logic [31:0] weight;
	logic        weight_missing;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        result_strobe;
	logic [7:0]  result_group;
	logic [47:0] spread;
	logic        result_na;
	logic [47:0] total_weight;

	grouped_weighted_variance u_top (.*);

	// Shadow copy of the group table and the registers.
	logic signed [63:0] mean_or_sum[256];
	logic [63:0]        sq_moment[256];
	logic [47:0]        wsum[256];
	logic               poison[256];
	logic [8:0]         groups_cfg;
	logic               running_cfg, stddev_cfg, skip_cfg, weights_cfg;

	spread_result_t pending_spreads[$];
	int errors = 0;
	int cycles = 0;
	int requests_sent = 0;
	int results_seen = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	function automatic logic [63:0] magnitude(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] root_of(input logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] sq;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= v) r = c;
		end
		return r;
	endfunction

	function automatic logic [47:0] spread_from(input logic [63:0] num, input logic [47:0] den);
		logic [127:0] q;
		logic [63:0]  r;
		if (stddev_cfg) begin
			q = ({64'd0, num} << 32) / {80'd0, den};
			r = root_of(q);
			return (r > {16'd0, CAP48}) ? CAP48 : r[47:0];
		end
		q = ({64'd0, num} << 16) / {80'd0, den};
		return (q > {80'd0, CAP48}) ? CAP48 : q[47:0];
	endfunction

	task automatic welford_add(input int g, input logic [63:0] xs, input logic [31:0] w,
			input logic [47:0] wnew);
		logic [63:0]  d, dm, e, em, mean, t, inc;
		logic [127:0] p, q;
		logic [64:0]  s;
		if (wnew == '0) return;
		mean = mean_or_sum[g];
		d = xs - mean;
		dm = magnitude(d);
		p = {64'd0, dm} * {96'd0, w};
		q = p / {80'd0, wnew};
		mean = d[63] ? mean - q[63:0] : mean + q[63:0];
		mean_or_sum[g] = mean;
		e = xs - mean;
		em = magnitude(e);
		p = {64'd0, dm} * {64'd0, em};
		t = p[111:48];
		p = {64'd0, t} * {96'd0, w};
		inc = (|p[127:80]) ? CAP64 : p[79:16];
		s = {1'b0, sq_moment[g]} + {1'b0, inc};
		sq_moment[g] = s[64] ? CAP64 : s[63:0];
	endtask

	task automatic sums_add(input int g, input logic [31:0] smp, input logic [31:0] w);
		logic signed [63:0] x, xw, wx;
		logic signed [64:0] s;
		logic [63:0]        xm, sq;
		logic [127:0]       p;
		logic [64:0]        u;
		x = {{32{smp[31]}}, smp};
		xw = x * $signed({32'd0, w});
		wx = xw / 64'sd65536;
		s = {mean_or_sum[g][63], mean_or_sum[g]} + {wx[63], wx};
		if (s[64] != s[63])
			mean_or_sum[g] = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			mean_or_sum[g] = s[63:0];
		xm = magnitude(x);
		sq = xm * xm;
		p = {64'd0, sq} * {96'd0, w};
		u = {1'b0, sq_moment[g]} + {1'b0, p[95:32]};
		sq_moment[g] = u[64] ? CAP64 : u[63:0];
	endtask

	task automatic predict_request(input logic [1:0] rq, input logic [7:0] gi,
			input logic [31:0] smp, input logic sm, input logic [31:0] win, input logic wm);
		int             active, g;
		logic [31:0]    w;
		logic [48:0]    wn;
		logic [47:0]    wnew;
		logic [63:0]    m, num;
		logic [127:0]   q;
		spread_result_t r;
		active = (groups_cfg < 256) ? int'(groups_cfg) : 256;
		g = int'(gi);
		w = weights_cfg ? win : 32'h0001_0000;
		if (g >= active) return;
		case (rq)
			REQ_ACC: begin
				if (poison[g]) return;
				if (sm || (weights_cfg && wm)) begin
					if (!skip_cfg) poison[g] = 1'b1;
					return;
				end
				wn = {1'b0, wsum[g]} + {17'd0, w};
				wnew = wn[48] ? CAP48 : wn[47:0];
				if (running_cfg) welford_add(g, {{16{smp[31]}}, smp, 16'd0}, w, wnew);
				else sums_add(g, smp, w);
				wsum[g] = wnew;
			end
			REQ_CLR: begin
				mean_or_sum[g] = '0;
				sq_moment[g] = '0;
				wsum[g] = '0;
				poison[g] = 1'b0;
			end
			REQ_QRY: begin
				r.grp = gi;
				r.tw = wsum[g];
				r.spr = '0;
				r.na = 1'b1;
				if (!poison[g] && wsum[g] > ONE_Q16) begin
					r.na = 1'b0;
					if (running_cfg) begin
						num = sq_moment[g];
					end else begin
						m = magnitude(mean_or_sum[g]);
						q = ({64'd0, m} * {64'd0, m}) / {80'd0, wsum[g]};
						num = (q > {64'd0, sq_moment[g]}) ? 64'd0 : sq_moment[g] - q[63:0];
					end
					r.spr = spread_from(num, wsum[g] - ONE_Q16);
				end
				pending_spreads.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(negedge clk) begin
		spread_result_t want;
		if (arst_n && result_strobe) begin
			results_seen++;
			if (pending_spreads.size() == 0) begin
				report("unexpected result, group", 64'(result_group), 64'd0);
			end else begin
				want = pending_spreads.pop_front();
				if (result_group !== want.grp)
					report("result_group", 64'(result_group), 64'(want.grp));
				if (spread !== want.spr) report("spread", 64'(spread), 64'(want.spr));
				if (result_na !== want.na)
					report("result_na", 64'(result_na), 64'(want.na));
				if (total_weight !== want.tw)
					report("total_weight", 64'(total_weight), 64'(want.tw));
			end
		end
	end

	function automatic int random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one request; returns at the rising edge at which it was taken.
	task automatic send_request(input logic [1:0] rq, input logic [7:0] gi,
			input logic [31:0] smp, input logic sm, input logic [31:0] w, input logic wm,
			input int gap);
		logic taken;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq;
		group_index <= gi;
		sample <= smp;
		sample_missing <= sm;
		weight <= w;
		weight_missing <= wm;
		do begin
			@(negedge clk);
			taken = !busy;
			if (taken) predict_request(rq, gi, smp, sm, w, wm);
			@(posedge clk);
		end while (!taken);
		requests_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_spreads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after its last write.
	task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GROUPS: groups_cfg = val;
			REG_RUNNING: running_cfg = val[0];
			REG_STD_DEV: stddev_cfg = val[0];
			REG_SKIP: skip_cfg = val[0];
			REG_WEIGHTS: weights_cfg = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [8:0] grp, input logic run, input logic sd,
			input logic skp, input logic wts);
		drain();
		write_reg(REG_GROUPS, grp);
		write_reg(REG_RUNNING, {8'd0, run});
		write_reg(REG_STD_DEV, {8'd0, sd});
		write_reg(REG_SKIP, {8'd0, skp});
		write_reg(REG_WEIGHTS, {8'd0, wts});
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		set_mode(9'd256, 1'b1, 1'b1, 1'b1, 1'b0);
		send_request(REQ_ACC, 8'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_ACC, 8'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_QRY, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_QRY, 8'd1, 32'h0, 1'b0, 32'h0, 1'b0, 1);
		send_request(REQ_ACC, 8'd255, 32'h0001_8000, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_QRY, 8'd255, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(2'd3, 8'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 0);
		send_request(REQ_ACC, 8'd0, 32'h1234_0000, 1'b1, 32'h0, 1'b0, 0);
		send_request(REQ_ACC, 8'd0, 32'h0002_0000, 1'b0, 32'h0, 1'b1, 0);
		send_request(REQ_QRY, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_CLR, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_QRY, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		// Missing data now poisons the group until it is cleared.
		set_mode(9'd256, 1'b0, 1'b0, 1'b0, 1'b1);
		send_request(REQ_ACC, 8'd2, 32'h0003_0000, 1'b0, 32'h0002_0000, 1'b0, 0);
		send_request(REQ_ACC, 8'd2, 32'h0003_0000, 1'b0, 32'h0002_0000, 1'b1, 0);
		send_request(REQ_ACC, 8'd2, 32'h0005_0000, 1'b0, 32'h0002_0000, 1'b0, 0);
		send_request(REQ_QRY, 8'd2, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_CLR, 8'd2, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_ACC, 8'd3, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 1'b0, 0);
		send_request(REQ_ACC, 8'd3, 32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 0);
		send_request(REQ_QRY, 8'd3, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		// Zero weight in running-mean mode leaves the group untouched.
		set_mode(9'd1, 1'b1, 1'b0, 1'b1, 1'b1);
		send_request(REQ_ACC, 8'd0, 32'h0004_0000, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_ACC, 8'd5, 32'h0004_0000, 1'b0, 32'h0001_0000, 1'b0, 0);
		send_request(REQ_QRY, 8'd5, 32'h0, 1'b0, 32'h0, 1'b0, 0);
		send_request(REQ_QRY, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0, 0);
	endtask

	task automatic random_phase(input int count);
		int          hot, gi, roll;
		logic [1:0]  rq;
		logic [31:0] smp, w;
		hot = (groups_cfg < 8) ? int'(groups_cfg) : 8;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			gi = (roll < 85) ? $urandom_range(0, hot - 1) : $urandom_range(0, 255);
			roll = $urandom_range(0, 99);
			rq = (roll < 68) ? REQ_ACC : (roll < 90) ? REQ_QRY : (roll < 96) ? REQ_CLR : 2'd3;
			roll = $urandom_range(0, 9);
			if (roll == 0) smp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			else if (roll < 5) smp = $urandom;
			else smp = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			roll = $urandom_range(0, 9);
			if (roll == 0) w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			else if (roll < 5) w = $urandom;
			else w = $urandom_range(0, 32'h0004_0000);
			send_request(rq, gi[7:0], smp, $urandom_range(0, 99) < 3, w,
				$urandom_range(0, 99) < 3, random_gap());
			if (n == count / 2 && $urandom_range(0, 1)) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_spreads.size() != 0);
			end
		end
	endtask

	task automatic test_settings();
		set_mode(9'd256, 1'b1, 1'b1, 1'b1, 1'b0);
		random_phase(270);
		set_mode(9'd1, 1'b0, 1'b0, 1'b0, 1'b1);
		random_phase(270);
		set_mode(9'd16, 1'b1, 1'b0, 1'b1, 1'b1);
		random_phase(270);
		set_mode(9'd256, 1'b0, 1'b1, 1'b1, 1'b0);
		random_phase(270);
		set_mode(9'd3, 1'b1, 1'b1, 1'b0, 1'b1);
		random_phase(270);
		set_mode(9'd255, 1'b0, 1'b1, 1'b0, 1'b1);
		random_phase(270);
		set_mode(9'd64, 1'b1, 1'b0, 1'b0, 1'b0);
		random_phase(270);
	endtask

	initial begin
		clk = 1'b0;
		for (int g = 0; g < 256; g++) begin
			mean_or_sum[g] = '0;
			sq_moment[g] = '0;
			wsum[g] = '0;
			poison[g] = 1'b0;
		end
		groups_cfg = 9'd256;
		running_cfg = 1'b1;
		stddev_cfg = 1'b1;
		skip_cfg = 1'b1;
		weights_cfg = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ACC;
		group_index = '0;
		sample = '0;
		sample_missing = 1'b0;
		weight = '0;
		weight_missing = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GROUPS;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		drain();
		$display("Sent %0d requests over several register settings; checked %0d query results.",
			requests_sent, results_seen);
		$display("Both update modes, variance and deviation, weights, missing data covered.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
